// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/etuc_pkg.sv =====
package etuc_pkg;

  localparam int InW   = 32;
  localparam int OutW  = 48;
  localparam int StepW = 4;

  typedef logic [StepW-1:0] step_t;
  typedef logic [3:0]       op_t;
  typedef logic [2:0]       jmp_t;

  // datapath operations
  localparam op_t OP_LOAD  = 4'd0;
  localparam op_t OP_DIV   = 4'd1;
  localparam op_t OP_SEC   = 4'd2;
  localparam op_t OP_MIN   = 4'd3;
  localparam op_t OP_HOUR  = 4'd4;
  localparam op_t OP_WDAY  = 4'd5;
  localparam op_t OP_YEAR  = 4'd6;
  localparam op_t OP_MONTH = 4'd7;
  localparam op_t OP_OUT   = 4'd8;
  localparam op_t OP_NONE  = 4'd9;

  // hold conditions: the step repeats while its condition is true
  localparam jmp_t J_NONE = 3'd0;
  localparam jmp_t J_IN   = 3'd1;
  localparam jmp_t J_DIV  = 3'd2;
  localparam jmp_t J_YEAR = 3'd3;
  localparam jmp_t J_MON  = 3'd4;
  localparam jmp_t J_OUT  = 3'd5;

  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [5:0] HOUR_PER_DAY = 6'd24;
  localparam logic [5:0] DAY_PER_WEEK = 6'd7;
  localparam logic [5:0] NO_DIVISOR   = 6'd0;

  // reciprocals: ceil(2^37/60), ceil(2^36/24), ceil(2^34/7)
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'h9249_2493;

  // thursday offset of the epoch day
  localparam logic [31:0] EPOCH_WDAY = 32'd4;

  localparam logic [7:0] YEAR_BASE = 8'd70;
  localparam logic [7:0] YEAR_LAST = 8'd206;
  localparam logic [7:0] YEAR_2100 = 8'd200;
  localparam logic [8:0] DAYS_YEAR = 9'd365;
  localparam logic [8:0] DAYS_LEAP = 9'd366;

  localparam logic [3:0] JANUARY    = 4'd0;
  localparam logic [3:0] FEBRUARY   = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  typedef struct packed {
    op_t        op;
    jmp_t       jmp;
    logic [5:0] divisor;
    step_t      target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic year_more;
    logic mon_more;
    logic out_busy;
  } status_t;

  // years 1970..2106 only: 2000 is a leap year, 2100 is not
  function automatic logic is_leap(logic [7:0] yr);
    return (yr[1:0] == 2'b00) && (yr != YEAR_2100);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/etuc_seq.sv =====
`include "assert_macros.svh"

module etuc_seq (
  input  logic              clk,
  input  logic              rst,
  input  etuc_pkg::status_t status,
  output etuc_pkg::ucode_t  cw
);
  import etuc_pkg::*;

  localparam step_t STEP_LOAD  = 4'd0;
  localparam step_t STEP_DIV_S = 4'd1;
  localparam step_t STEP_SEC   = 4'd2;
  localparam step_t STEP_DIV_M = 4'd3;
  localparam step_t STEP_MIN   = 4'd4;
  localparam step_t STEP_DIV_H = 4'd5;
  localparam step_t STEP_HOUR  = 4'd6;
  localparam step_t STEP_DIV_W = 4'd7;
  localparam step_t STEP_WDAY  = 4'd8;
  localparam step_t STEP_YEAR  = 4'd9;
  localparam step_t STEP_MONTH = 4'd10;
  localparam step_t STEP_OUT   = 4'd11;

  step_t pc;
  step_t pc_next;
  logic  hold;

  // microcode rom
  always_comb begin
    case (pc)
      STEP_LOAD:  cw = '{op: OP_LOAD,  jmp: J_IN,   divisor: NO_DIVISOR,   target: STEP_DIV_S};
      STEP_DIV_S: cw = '{op: OP_DIV,   jmp: J_DIV,  divisor: SEC_PER_MIN,  target: STEP_SEC};
      STEP_SEC:   cw = '{op: OP_SEC,   jmp: J_NONE, divisor: NO_DIVISOR,   target: STEP_DIV_M};
      STEP_DIV_M: cw = '{op: OP_DIV,   jmp: J_DIV,  divisor: MIN_PER_HOUR, target: STEP_MIN};
      STEP_MIN:   cw = '{op: OP_MIN,   jmp: J_NONE, divisor: NO_DIVISOR,   target: STEP_DIV_H};
      STEP_DIV_H: cw = '{op: OP_DIV,   jmp: J_DIV,  divisor: HOUR_PER_DAY, target: STEP_HOUR};
      STEP_HOUR:  cw = '{op: OP_HOUR,  jmp: J_NONE, divisor: NO_DIVISOR,   target: STEP_DIV_W};
      STEP_DIV_W: cw = '{op: OP_DIV,   jmp: J_DIV,  divisor: DAY_PER_WEEK, target: STEP_WDAY};
      STEP_WDAY:  cw = '{op: OP_WDAY,  jmp: J_NONE, divisor: NO_DIVISOR,   target: STEP_YEAR};
      STEP_YEAR:  cw = '{op: OP_YEAR,  jmp: J_YEAR, divisor: NO_DIVISOR,   target: STEP_MONTH};
      STEP_MONTH: cw = '{op: OP_MONTH, jmp: J_MON,  divisor: NO_DIVISOR,   target: STEP_OUT};
      STEP_OUT:   cw = '{op: OP_OUT,   jmp: J_OUT,  divisor: NO_DIVISOR,   target: STEP_LOAD};
      default:    cw = '{op: OP_NONE,  jmp: J_NONE, divisor: NO_DIVISOR,   target: STEP_LOAD};
    endcase
  end

  always_comb begin
    case (cw.jmp)
      J_IN:    hold = !status.in_fire;
      J_DIV:   hold = !status.div_last;
      J_YEAR:  hold = status.year_more;
      J_MON:   hold = status.mon_more;
      J_OUT:   hold = status.out_busy;
      default: hold = 1'b0;
    endcase
    pc_next = hold ? pc : cw.target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  `ASSERT_NEXT(a_out_back_to_load, clk, rst, (cw.op == OP_OUT) && !status.out_busy, pc == STEP_LOAD, "sequencer did not return to load after output")
  `ASSERT_NEXT(a_load_waits_for_word, clk, rst, (pc == STEP_LOAD) && !status.in_fire, pc == STEP_LOAD, "sequencer left load without a word")
  `ASSERT_CLK(a_pc_in_program, clk, rst, pc <= STEP_OUT, "step counter left the program")

endmodule

// ===== sv/etuc_dpath.sv =====
`include "assert_macros.svh"

module etuc_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  etuc_pkg::ucode_t            cw,
  output etuc_pkg::status_t           status,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [etuc_pkg::InW-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [etuc_pkg::OutW-1:0]   m_axis_tdata
);
  import etuc_pkg::*;

  logic [31:0] num;
  logic [5:0]  rem;
  logic        cnt;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hour;
  logic [2:0]  wday;
  logic [15:0] days;
  logic [7:0]  yr;
  logic [8:0]  yday;
  logic [3:0]  mon;

  logic [63:0] prod;
  logic [31:0] recip;
  logic [31:0] quo;
  logic [11:0] qd;
  logic [5:0]  rem_low;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        in_fire, out_busy;
  logic [OutW-1:0] out_word;

  // reciprocal division: product first, then quotient and remainder
  always_comb begin
    case (cw.divisor)
      // also minutes per hour
      SEC_PER_MIN: begin
        recip = RECIP_60;
        quo   = {5'd0, prod[63:37]};
      end
      HOUR_PER_DAY: begin
        recip = RECIP_24;
        quo   = {4'd0, prod[63:36]};
      end
      DAY_PER_WEEK: begin
        recip = RECIP_7;
        quo   = {2'd0, prod[63:34]};
      end
      default: begin
        recip = '0;
        quo   = '0;
      end
    endcase
    qd      = {6'd0, quo[5:0]} * {6'd0, cw.divisor};
    rem_low = num[5:0] - qd[5:0];
  end

  always_comb begin
    leap     = is_leap(yr);
    ylen     = leap ? DAYS_LEAP : DAYS_YEAR;
    mlen     = month_len(mon, leap);
    s_axis_tready = (cw.op == OP_LOAD) && !rst;
    in_fire  = s_axis_tvalid && s_axis_tready;
    out_busy = m_axis_tvalid && !m_axis_tready;
    status.in_fire   = in_fire;
    status.div_last  = cnt;
    status.year_more = days >= {7'b0, ylen};
    status.mon_more  = (days >= {11'b0, mlen}) && (mon != MONTH_LAST);
    status.out_busy  = out_busy;
    out_word = {2'b00, days[4:0] + 5'd1, mon, yday, yr, wday, hour, min, sec};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cw.op == OP_DIV) begin
        cnt <= ~cnt;
      end
      if ((cw.op == OP_OUT) && !out_busy) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_fire) begin
          num <= s_axis_tdata;
          rem <= 6'd0;
        end
      end
      OP_DIV: begin
        if (!cnt) begin
          prod <= {32'd0, num} * {32'd0, recip};
        end else begin
          num <= quo;
          rem <= rem_low;
        end
      end
      OP_SEC: begin
        sec <= rem;
        rem <= 6'd0;
      end
      OP_MIN: begin
        min <= rem;
        rem <= 6'd0;
      end
      OP_HOUR: begin
        hour <= rem[4:0];
        days <= num[15:0];
        num  <= num + EPOCH_WDAY;
        rem  <= 6'd0;
      end
      OP_WDAY: begin
        wday <= rem[2:0];
        yr   <= YEAR_BASE;
        mon  <= JANUARY;
      end
      OP_YEAR: begin
        if (status.year_more) begin
          days <= days - {7'b0, ylen};
          yr   <= yr + 8'd1;
        end else begin
          yday <= days[8:0];
        end
      end
      OP_MONTH: begin
        if (status.mon_more) begin
          days <= days - {11'b0, mlen};
          mon  <= mon + 4'd1;
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          m_axis_tdata <= out_word;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_CLK(a_rem_below_divisor, clk, rst, (cw.op == OP_DIV) |-> (rem < cw.divisor), "remainder not below divisor")
  `ASSERT_CLK(a_out_time_range, clk, rst, m_axis_tvalid |-> ((m_axis_tdata[5:0] < 6'd60) && (m_axis_tdata[11:6] < 6'd60) && (m_axis_tdata[16:12] < 5'd24) && (m_axis_tdata[19:17] != 3'd7)), "time of day out of range")
  `ASSERT_CLK(a_year_bounded, clk, rst, (cw.op == OP_YEAR) |-> (yr <= YEAR_LAST), "year walk ran past the input range")

endmodule

// ===== sv/epoch_seconds_to_utc_calendar.sv =====
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// the broken-down UTC calendar time. One word is taken at a time. The four
// divisions (by 60, 60, 24 and 7) share one reciprocal multiplier; each one
// first registers the product and then the quotient and remainder. The year
// and month walks subtract one year or one month length per cycle. The
// result sits in an output register, so the next word is accepted as soon
// as the previous result has been loaded, even while that result still
// waits to be taken.
module epoch_seconds_to_utc_calendar (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // epoch_seconds
  input  logic [etuc_pkg::InW-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // second_of_minute, minute_of_hour, hour_of_day, day_of_week,
  // years_since_1900, day_of_year, month_index, day_of_month, zero pad
  output logic [etuc_pkg::OutW-1:0]   m_axis_tdata
);
  import etuc_pkg::*;

  ucode_t  cw;
  status_t status;

  etuc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  etuc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cw            (cw),
    .status        (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
